FILE: design/spq_pkg.sv
package spq_pkg;

    localparam int SAMPLE_W = 10;
    localparam int NOTE_W   = 7;
    localparam int WORD_W   = 16;
    localparam int MASK_W   = 12;
    localparam int BASE_W   = 4;
    localparam int OFF_W    = 4;
    localparam int PITCH_W  = 17;
    localparam int CUR_W    = 9;
    localparam int DIST_W   = 19;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_BASE_NOTE  = 2'd0;
    localparam cfg_idx_t CFG_SCALE_MASK = 2'd1;

    localparam logic [BASE_W-1:0] BASE_RESET = 4'd0;
    localparam logic [MASK_W-1:0] MASK_RESET = 12'hAD5;

    localparam logic [CNT_W-1:0] SCAN_LAST = 4'd11;
    localparam logic [OFF_W-1:0] OFF_TOP   = 4'd11;

    // millivolt code: (note * 47069 + 500) / 1000, divide done by reciprocal
    localparam logic [15:0] MV_NUM      = 16'd47069;
    localparam logic [22:0] MV_HALF     = 23'd500;
    localparam logic [23:0] MV_RECIP    = 24'd8589935;
    localparam logic [WORD_W-1:0] DAC_PREFIX_A = 16'h1000;
    localparam logic [WORD_W-1:0] DAC_PREFIX_B = 16'h9000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_MUL,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic             up_hit;
        logic             up_stop;
        logic             dn_hit;
        logic             dn_stop;
        logic [OFF_W-1:0] up_off;
        logic [OFF_W-1:0] dn_off;
    } scan_res_t;

    typedef struct packed {
        logic start;
        logic channel;
    } dac_req_t;

    // (n - base) mod 12 for a 7-bit note, using 16 = 4 (mod 12)
    function automatic logic [OFF_W-1:0] pc_offset(input logic [NOTE_W-1:0] n,
                                                   input logic [BASE_W-1:0] b);
        logic [5:0]       x;
        logic [OFF_W-1:0] bm;
        logic [OFF_W-1:0] r;
        x = {1'b0, n[6:4], 2'b00} + {2'b00, n[3:0]};
        if (x >= 6'd36)
            x = x - 6'd36;
        if (x >= 6'd24)
            x = x - 6'd24;
        if (x >= 6'd12)
            x = x - 6'd12;
        bm = (b >= 4'd12) ? b - 4'd12 : b;
        if (x[3:0] >= bm)
            r = x[3:0] - bm;
        else
            r = x[3:0] + 4'd12 - bm;
        return r;
    endfunction

endpackage

FILE: design/spq_if.sv
interface spq_in_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::SAMPLE_W-1:0] sample;
    logic                         channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface spq_out_if;
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::NOTE_W-1:0] note;
    logic [spq_pkg::WORD_W-1:0] dac_word;

    modport source (output valid, output note, output dac_word, input ready);
    modport sink   (input valid, input note, input dac_word, output ready);
endinterface

interface spq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spq_pkg::CFG_IDX_W-1:0]  index;
    logic [spq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/spq_step.sv
module spq_step #(
    parameter int LOWEST_NOTE  = 21,
    parameter int HIGHEST_NOTE = 108
) (
    input  logic signed [spq_pkg::CUR_W-1:0]  up_note,
    input  logic        [spq_pkg::OFF_W-1:0]  up_off,
    input  logic signed [spq_pkg::CUR_W-1:0]  dn_note,
    input  logic        [spq_pkg::OFF_W-1:0]  dn_off,
    input  logic        [spq_pkg::MASK_W-1:0] mask,
    output spq_pkg::scan_res_t                res
);

    localparam logic signed [spq_pkg::CUR_W-1:0] Hi = spq_pkg::CUR_W'(HIGHEST_NOTE);
    localparam logic signed [spq_pkg::CUR_W-1:0] Lo = spq_pkg::CUR_W'(LOWEST_NOTE);

    logic [spq_pkg::OFF_W-1:0] up_bit;
    logic [spq_pkg::OFF_W-1:0] dn_bit;

    // bit 11 of the mask is offset 0
    assign up_bit = spq_pkg::OFF_TOP - up_off;
    assign dn_bit = spq_pkg::OFF_TOP - dn_off;

    always_comb
    begin
        res.up_stop = up_note > Hi;
        res.dn_stop = dn_note < Lo;
        res.up_hit  = !res.up_stop && mask[up_bit];
        res.dn_hit  = !res.dn_stop && mask[dn_bit];
        res.up_off  = (up_off == spq_pkg::OFF_TOP) ? '0 : up_off + 4'd1;
        res.dn_off  = (dn_off == '0) ? spq_pkg::OFF_TOP : dn_off - 4'd1;
    end

endmodule

FILE: design/spq_dac.sv
module spq_dac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_pkg::dac_req_t          req,
    input  logic [spq_pkg::NOTE_W-1:0] note,
    output logic                       done,
    output logic [spq_pkg::WORD_W-1:0] word
);

    logic        v1_reg;
    logic        done_reg;
    logic        ch_reg;
    logic [22:0] y_reg;
    logic [22:0] y_next;
    logic [46:0] prod;
    logic [11:0] mv;
    logic [spq_pkg::WORD_W-1:0] word_reg;
    logic [spq_pkg::WORD_W-1:0] word_next;

    assign y_next = ({16'b0, note} * {7'b0, spq_pkg::MV_NUM}) + spq_pkg::MV_HALF;

    // floor(y / 1000) as (y * ceil(2^33 / 1000)) >> 33, exact for y below 2^24
    assign prod      = {24'b0, y_reg} * {23'b0, spq_pkg::MV_RECIP};
    assign mv        = prod[44:33];
    assign word_next = (ch_reg ? spq_pkg::DAC_PREFIX_B : spq_pkg::DAC_PREFIX_A)
                       | {4'b0, mv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            y_reg  <= y_next;
            ch_reg <= req.channel;
        end
        if (v1_reg)
            word_reg <= word_next;
    end

    assign done = done_reg;
    assign word = word_reg;

endmodule

FILE: design/scale_pitch_quantizer.sv
// scale pitch quantizer
// req: one transfer carries a 10-bit cv sample and a dac channel bit.
// rsp: one transfer carries the in-scale midi note and the 16-bit dac word.
// cfg: register 0 is the scale root (base_note), register 1 the 12-bit
//      scale mask (bit 11 is the root); always ready, write only while idle.
// the sample becomes a pitch in 1/1024-note steps, then a search walks up
// from the ceiling and down from the floor, one note per direction per
// cycle, through a shared scale-membership unit. an item passes through a
// setup state, the scan, a pick state and the two-stage dac code
// multiplier; req.ready rises again in the same cycle as rsp.valid. one
// item is in flight at a time, so a new transfer is not taken until the
// last item has moved into the output register.
// the result sits in an output register; a new item may be accepted while
// it waits. if the receiver stalls with the output still full, the block
// holds its finished result and stays busy until the slot frees.
// reset empties the output, returns to idle and sets the root to c and
// the mask to the major scale.
module scale_pitch_quantizer #(
    parameter int LOWEST_NOTE  = 21,
    parameter int HIGHEST_NOTE = 108
) (
    input logic        clk,
    input logic        rst_n,
    spq_in_if.sink     req,
    spq_out_if.source  rsp,
    spq_cfg_if.sink    cfg
);

    localparam logic signed [18:0] SpanS = 19'(HIGHEST_NOTE - LOWEST_NOTE);
    localparam logic signed [18:0] BaseP = 19'(LOWEST_NOTE * 1024);
    localparam logic [spq_pkg::NOTE_W-1:0] HiNote = spq_pkg::NOTE_W'(HIGHEST_NOTE);
    localparam logic [spq_pkg::NOTE_W-1:0] LoNote = spq_pkg::NOTE_W'(LOWEST_NOTE);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    logic [spq_pkg::BASE_W-1:0] base_reg;
    logic [spq_pkg::MASK_W-1:0] mask_reg;

    logic [spq_pkg::PITCH_W-1:0]      p_reg;
    logic                             chan_reg;
    logic signed [spq_pkg::CUR_W-1:0] up_cur_reg;
    logic signed [spq_pkg::CUR_W-1:0] dn_cur_reg;
    logic [spq_pkg::OFF_W-1:0]        up_off_reg;
    logic [spq_pkg::OFF_W-1:0]        dn_off_reg;
    logic [spq_pkg::NOTE_W-1:0]       up_val_reg;
    logic [spq_pkg::NOTE_W-1:0]       dn_val_reg;
    logic                             up_done_reg;
    logic                             dn_done_reg;
    logic [spq_pkg::CNT_W-1:0]        cnt_reg;
    logic [spq_pkg::NOTE_W-1:0]       note_reg;

    logic                       out_valid_reg;
    logic [spq_pkg::NOTE_W-1:0] out_note_reg;
    logic [spq_pkg::WORD_W-1:0] out_word_reg;

    logic signed [18:0] samp_s;
    logic signed [37:0] prod;
    logic signed [18:0] p_full;

    logic [spq_pkg::NOTE_W-1:0] fl;
    logic                       frac;
    logic [spq_pkg::OFF_W-1:0]  off_fl;

    spq_pkg::scan_res_t sres;
    logic               up_fin;
    logic               dn_fin;
    logic               scan_end;

    logic signed [spq_pkg::DIST_W-1:0] p_w;
    logic signed [spq_pkg::DIST_W-1:0] du;
    logic signed [spq_pkg::DIST_W-1:0] dd;
    logic [spq_pkg::DIST_W-1:0]        adu;
    logic [spq_pkg::DIST_W-1:0]        add;
    logic [spq_pkg::NOTE_W-1:0]        pick;

    spq_pkg::dac_req_t          dreq;
    logic                       dac_done;
    logic [spq_pkg::WORD_W-1:0] dac_word;

    logic in_xfer;
    logic slot_free;
    logic load_out;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= spq_pkg::BASE_RESET;
            mask_reg <= spq_pkg::MASK_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                spq_pkg::CFG_BASE_NOTE:  base_reg <= cfg.data[spq_pkg::BASE_W-1:0];
                spq_pkg::CFG_SCALE_MASK: mask_reg <= cfg.data[spq_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // pitch in 1/1024 notes, never negative for any legal parameters
    assign samp_s = $signed({9'b0, req.sample});
    assign prod   = samp_s * SpanS;
    assign p_full = BaseP + $signed(prod[18:0]);

    assign fl     = p_reg[16:10];
    assign frac   = |p_reg[9:0];
    assign off_fl = spq_pkg::pc_offset(fl, base_reg);

    spq_step #(
        .LOWEST_NOTE  (LOWEST_NOTE),
        .HIGHEST_NOTE (HIGHEST_NOTE)
    ) u_step (
        .up_note (up_cur_reg),
        .up_off  (up_off_reg),
        .dn_note (dn_cur_reg),
        .dn_off  (dn_off_reg),
        .mask    (mask_reg),
        .res     (sres)
    );

    assign up_fin   = up_done_reg || sres.up_hit || sres.up_stop;
    assign dn_fin   = dn_done_reg || sres.dn_hit || sres.dn_stop;
    // the scale repeats every 12 notes, so 12 steps settle both searches
    assign scan_end = (cnt_reg == spq_pkg::SCAN_LAST) || (up_fin && dn_fin);

    // nearer candidate wins, tie goes down
    always_comb
    begin
        p_w  = $signed({2'b0, p_reg});
        du   = $signed({2'b0, up_val_reg, 10'b0}) - p_w;
        dd   = p_w - $signed({2'b0, dn_val_reg, 10'b0});
        adu  = du[spq_pkg::DIST_W-1] ? 19'(-du) : 19'(du);
        add  = dd[spq_pkg::DIST_W-1] ? 19'(-dd) : 19'(dd);
        pick = (adu < add) ? up_val_reg : dn_val_reg;
    end

    spq_dac u_dac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .note  (pick),
        .done  (dac_done),
        .word  (dac_word)
    );

    assign slot_free = !out_valid_reg || rsp.ready;
    assign in_xfer   = req.valid && req.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE: if (req.valid) state_next = spq_pkg::ST_INIT;
            spq_pkg::ST_INIT: state_next = spq_pkg::ST_SCAN;
            spq_pkg::ST_SCAN: if (scan_end) state_next = spq_pkg::ST_PICK;
            spq_pkg::ST_PICK: state_next = spq_pkg::ST_MUL;
            spq_pkg::ST_MUL:
            begin
                if (dac_done)
                    state_next = slot_free ? spq_pkg::ST_IDLE : spq_pkg::ST_HOLD;
            end
            spq_pkg::ST_HOLD: if (slot_free) state_next = spq_pkg::ST_IDLE;
            default: state_next = spq_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready     = 1'b0;
        dreq.start    = 1'b0;
        dreq.channel  = chan_reg;
        load_out      = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE: req.ready = 1'b1;
            spq_pkg::ST_PICK: dreq.start = 1'b1;
            spq_pkg::ST_MUL:  load_out = dac_done && slot_free;
            spq_pkg::ST_HOLD: load_out = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            p_reg    <= p_full[spq_pkg::PITCH_W-1:0];
            chan_reg <= req.channel;
        end

        if (state_reg == spq_pkg::ST_INIT)
        begin
            dn_cur_reg  <= $signed({2'b0, fl});
            dn_off_reg  <= off_fl;
            up_cur_reg  <= $signed({2'b0, fl}) + $signed({8'b0, frac});
            if (frac)
                up_off_reg <= (off_fl == spq_pkg::OFF_TOP) ? '0 : off_fl + 4'd1;
            else
                up_off_reg <= off_fl;
            up_val_reg  <= HiNote;
            dn_val_reg  <= LoNote;
            up_done_reg <= 1'b0;
            dn_done_reg <= 1'b0;
            cnt_reg     <= '0;
        end

        if (state_reg == spq_pkg::ST_SCAN)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (!up_done_reg)
            begin
                if (sres.up_hit || sres.up_stop)
                    up_done_reg <= 1'b1;
                if (sres.up_hit)
                    up_val_reg <= up_cur_reg[spq_pkg::NOTE_W-1:0];
                up_cur_reg <= up_cur_reg + 9'sd1;
                up_off_reg <= sres.up_off;
            end
            if (!dn_done_reg)
            begin
                if (sres.dn_hit || sres.dn_stop)
                    dn_done_reg <= 1'b1;
                if (sres.dn_hit)
                    dn_val_reg <= dn_cur_reg[spq_pkg::NOTE_W-1:0];
                dn_cur_reg <= dn_cur_reg - 9'sd1;
                dn_off_reg <= sres.dn_off;
            end
        end

        if (state_reg == spq_pkg::ST_PICK)
            note_reg <= pick;

        if (load_out)
        begin
            out_note_reg <= note_reg;
            out_word_reg <= dac_word;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.note     = out_note_reg;
    assign rsp.dac_word = out_word_reg;

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        dac_done |-> state_reg == spq_pkg::ST_MUL)
        else $error("dac result outside multiply wait");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::ST_SCAN |-> cnt_reg <= spq_pkg::SCAN_LAST)
        else $error("scan ran past twelve steps");

    a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == spq_pkg::ST_INIT)
        else $error("accepted item did not start setup");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == spq_pkg::ST_MUL)
                             || $past(state_reg == spq_pkg::ST_HOLD))
        else $error("result appeared without a finished item");

endmodule
